### rtl/rinse_tank_level_valve_pump_controller_top_defines.svh
// Assertion macros for the rinse tank controller.
`ifndef RINSE_TANK_LEVEL_VALVE_PUMP_CONTROLLER_TOP_DEFINES_SVH
`define RINSE_TANK_LEVEL_VALVE_PUMP_CONTROLLER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define RT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define RT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/rtlvp_pkg.sv
// Package: constants and types of the rinse tank controller.
package rtlvp_pkg;
  localparam logic [1:0] MODE_PLATE = 2'd0;
  localparam logic [1:0] MODE_AREA  = 2'd1;
  localparam logic [1:0] MODE_FRESH = 2'd2;

  localparam logic [2:0] REG_REPL_MODE  = 3'd0;
  localparam logic [2:0] REG_DOSE_PLATE = 3'd1;
  localparam logic [2:0] REG_DOSE_AREA  = 3'd2;
  localparam logic [2:0] REG_PUMP_RATE  = 3'd3;
  localparam logic [2:0] REG_MIN_VALVE  = 3'd4;
  localparam logic [2:0] REG_FLOW_CHECK = 3'd5;

  localparam int unsigned T_LEVEL     = 500;
  localparam int unsigned T_ERROR     = 2000;
  localparam int unsigned T_REFILL    = 200;
  localparam int unsigned T_SAFETY    = 1000;
  localparam int unsigned T_NOFLOW    = 300;
  localparam int unsigned T_CUTOFF    = 3000;
  localparam int unsigned T_FLOWSTART = 2000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_SCALE, ST_APPLY, ST_OUT
  } state_e;

  // Divider request and status.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage

### rtl/rtlvp_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module rtlvp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtlvp_pkg::div_req_t req_i,
  output rtlvp_pkg::div_rsp_t rsp_o
);
  logic [31:0] quo_q, quo_d;
  logic [15:0] div_q, div_d;
  logic [15:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [16:0] trial;

  always_comb begin
    quo_d = quo_q; div_d = div_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (req_i.start) begin
      quo_d = req_i.dividend; div_d = req_i.divisor; rem_d = '0;
      cnt_d = 6'd32; busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[31]};
      // the partial remainder stays below the divisor, so 16 bits hold it
      if (trial >= {1'b0, div_q}) begin
        rem_d = 16'(trial - {1'b0, div_q});
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; div_q <= div_d; rem_q <= rem_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

### rtl/rinse_tank_level_valve_pump_controller_top.sv
// Top level of the rinse tank level, valve and pump controller.
// Usage:
//  s_axis carries one 10 ms tick per transaction; m_axis returns one result
//  transaction per tick with the valve, pump and alarm drives and the valve
//  pulse times. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i
//  and the user must do so only while the block is idle; the block itself does not enforce it.
//  A tick without a dose calculation passes through MUL and APPLY; when a one
//  second pulse arrives while processing in plate or area mode, it also waits in
//  DIV for the 32-step serial divider (one quotient bit per cycle), then SCALE.
//  One tick is worked at a time: s_axis_tready is low from acceptance until
//  the result transaction has been taken.
//  Reset clears all timers, counters and flags; pump rate resets to one.
//  When the receiver stalls, the result is held in the output register
//  and no new tick is accepted.
`include "rinse_tank_level_valve_pump_controller_top_defines.svh"
module rinse_tank_level_valve_pump_controller_top #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tank_full, second_pulse, processing, auto_mode, voltage_ok, module_present,
  // flow_seen, plates_added[3:0], area_added[7:0], pump_cmd_set, pump_cmd_clear, pad
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // valve_open, pump_on, level_bad, level_alarm, flow_alarm, valve_time[15:0],
  // valve_time_left[15:0], pad
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned TB = TIMER_BITS;
  localparam logic [TB-1:0] TMAX = {TB{1'b1}};

  function automatic logic [TB-1:0] clip(input int unsigned p);
    logic [32:0] w;
    w = 33'(p);
    return (w > 33'(TMAX)) ? TMAX : w[TB-1:0];
  endfunction

  localparam logic [TB-1:0] P_LEVEL = clip(rtlvp_pkg::T_LEVEL);
  localparam logic [TB-1:0] P_ERROR = clip(rtlvp_pkg::T_ERROR);
  localparam logic [TB-1:0] P_REFILL = clip(rtlvp_pkg::T_REFILL);
  localparam logic [TB-1:0] P_SAFETY = clip(rtlvp_pkg::T_SAFETY);
  localparam logic [TB-1:0] P_NOFLOW = clip(rtlvp_pkg::T_NOFLOW);
  localparam logic [TB-1:0] P_CUTOFF = clip(rtlvp_pkg::T_CUTOFF);
  localparam logic [TB-1:0] P_FSTART = clip(rtlvp_pkg::T_FLOWSTART);

  // configuration
  logic [1:0]  mode_q;
  logic [15:0] dplate_q, darea_q, rate_q, minv_q;
  logic        fchk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0; dplate_q <= '0; darea_q <= '0; rate_q <= 16'd1;
      minv_q <= '0; fchk_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rtlvp_pkg::REG_REPL_MODE:  mode_q   <= cfg_data_i[1:0];
        rtlvp_pkg::REG_DOSE_PLATE: dplate_q <= cfg_data_i;
        rtlvp_pkg::REG_DOSE_AREA:  darea_q  <= cfg_data_i;
        rtlvp_pkg::REG_PUMP_RATE:  rate_q   <= cfg_data_i;
        rtlvp_pkg::REG_MIN_VALVE:  minv_q   <= cfg_data_i;
        rtlvp_pkg::REG_FLOW_CHECK: fchk_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // state
  rtlvp_pkg::state_e st_q, st_d;
  logic [20:0] in_q;
  logic [TB-1:0] ok_t_q, low_t_q, err_t_q, fs_t_q, nf_t_q, rf_t_q, co_t_q, sc_t_q, pe_q;
  logic [TB-1:0] ok_t_d, low_t_d, err_t_d, fs_t_d, nf_t_d, rf_t_d, co_t_d, sc_t_d, pe_d;
  logic [15:0] preset_q, preset_d, latest_q, latest_d, held_q, held_d;
  logic [15:0] pcnt_q, pcnt_d, acnt_q, acnt_d;
  logic [13:0] fl_q, fl_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] quo_q, quo_d;
  logic        capt;
  logic [39:0] out_q, out_d;
  logic        ovld_q;

  rtlvp_pkg::div_req_t dreq;
  rtlvp_pkg::div_rsp_t drsp;

  rtlvp_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  localparam int F_LB = 0, F_V = 1, F_P = 2, F_C = 3, F_RA = 4, F_RI = 5, F_FA = 6;
  localparam int F_PO = 7, F_PL = 8, F_PT = 9, F_PF = 10, F_PC = 11, F_TQ = 12, F_TI = 13;

  // input fields of the held transaction
  logic full, pls, proc, autom, volt, modp, flow, cset, cclr;
  logic [3:0] plates;
  logic [7:0] area;
  assign full = in_q[0]; assign pls = in_q[1]; assign proc = in_q[2];
  assign autom = in_q[3]; assign volt = in_q[4]; assign modp = in_q[5];
  assign flow = in_q[6]; assign plates = in_q[10:7]; assign area = in_q[18:11];
  assign cset = in_q[19]; assign cclr = in_q[20];

  logic dose_needed, use_plate;
  logic [16:0] psum, asum;
  logic [15:0] pcnt_a, acnt_a;
  assign psum = {1'b0, pcnt_q} + 17'(plates);
  assign asum = {1'b0, acnt_q} + 17'(area);
  assign pcnt_a = psum[16] ? 16'hFFFF : psum[15:0];
  assign acnt_a = asum[16] ? 16'hFFFF : asum[15:0];
  assign use_plate = (mode_q == rtlvp_pkg::MODE_PLATE);
  assign dose_needed = pls && proc &&
    (mode_q == rtlvp_pkg::MODE_PLATE || mode_q == rtlvp_pkg::MODE_AREA);

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      rtlvp_pkg::ST_IDLE:  if (s_axis_tvalid) st_d = rtlvp_pkg::ST_MUL;
      rtlvp_pkg::ST_MUL:   st_d = dose_needed ? rtlvp_pkg::ST_DIV : rtlvp_pkg::ST_APPLY;
      rtlvp_pkg::ST_DIV:   if (drsp.done) st_d = rtlvp_pkg::ST_SCALE;
      rtlvp_pkg::ST_SCALE: st_d = rtlvp_pkg::ST_APPLY;
      rtlvp_pkg::ST_APPLY: st_d = rtlvp_pkg::ST_OUT;
      rtlvp_pkg::ST_OUT:   if (!ovld_q || m_axis_tready) st_d = rtlvp_pkg::ST_IDLE;
      default:             st_d = rtlvp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (st_q == rtlvp_pkg::ST_IDLE) && !ovld_q;
    dreq.start    = (st_q == rtlvp_pkg::ST_MUL) && dose_needed;
    dreq.dividend = prod_d;
    dreq.divisor  = (rate_q == 16'd0) ? 16'd1 : rate_q;
    capt          = (st_q == rtlvp_pkg::ST_APPLY);
  end

  // multiply count by dose; scale quotient by 100
  always_comb begin
    prod_d = prod_q; quo_d = quo_q;
    if (st_q == rtlvp_pkg::ST_MUL)
      prod_d = use_plate ? pcnt_a * dplate_q : acnt_a * darea_q;
    if (st_q == rtlvp_pkg::ST_DIV && drsp.done) quo_d = drsp.quotient;
  end

  logic [38:0] scaled;
  logic [15:0] dt_sat;
  assign scaled = 39'(quo_q) * 39'd100;
  assign dt_sat = (scaled > 39'hFFFF) ? 16'hFFFF : scaled[15:0];

  logic [15:0] dt_q;
  always_ff @(posedge clk_i) begin
    if (st_q == rtlvp_pkg::ST_SCALE) dt_q <= dt_sat;
  end

  // on-delay helper
  function automatic logic [TB:0] ondly(input logic [TB-1:0] et, input logic in,
                                        input logic [TB-1:0] p);
    logic [TB-1:0] n;
    n = et;
    if (!in) return '0;
    if (n < p) n = n + 1'b1;
    return {(n >= p), n};
  endfunction

  // tick evaluation in statement order
  always_comb begin
    logic [TB:0] r;
    logic fresh, trig, q, lalarm, vwas, clk, fall, cr, d, tin;
    logic [15:0] left;
    ok_t_d = ok_t_q; low_t_d = low_t_q; err_t_d = err_t_q; fs_t_d = fs_t_q;
    nf_t_d = nf_t_q; rf_t_d = rf_t_q; co_t_d = co_t_q; sc_t_d = sc_t_q; pe_d = pe_q;
    preset_d = preset_q; latest_d = latest_q; held_d = held_q;
    pcnt_d = pcnt_q; acnt_d = acnt_q; fl_d = fl_q; out_d = out_q;
    fresh = (mode_q == rtlvp_pkg::MODE_FRESH);
    trig = 1'b0; r = '0; q = 1'b0; d = 1'b0;

    if (cset) fl_d[F_C] = 1'b1;
    if (cclr) fl_d[F_C] = 1'b0;
    pcnt_d = pcnt_a; acnt_d = acnt_a;

    r = ondly(ok_t_q, full, P_LEVEL); ok_t_d = r[TB-1:0]; q = r[TB];
    if (q && !fl_d[F_PO]) fl_d[F_LB] = 1'b0;
    fl_d[F_PO] = q;
    r = ondly(low_t_q, !full, P_LEVEL); low_t_d = r[TB-1:0]; q = r[TB];
    if (q && !fl_d[F_PL]) fl_d[F_LB] = 1'b1;
    fl_d[F_PL] = q;
    r = ondly(err_t_q, fl_d[F_LB], P_ERROR); err_t_d = r[TB-1:0]; q = r[TB];
    lalarm = modp && q && !fresh;

    if (dose_needed) begin
      latest_d = dt_q;
      if (dt_q >= minv_q) begin
        trig = 1'b1;
        if (use_plate) pcnt_d = '0; else acnt_d = '0;
      end
    end
    vwas = fl_d[F_V];
    if (!vwas) held_d = latest_d;
    if (trig && !vwas) preset_d = held_d;
    left = vwas ? (preset_d - 16'(pe_q)) : 16'd0;

    // pulse timer
    begin
      logic [TB:0] pw;
      logic [TB-1:0] p;
      pw = {{(TB+1-16 > 0 ? TB+1-16 : 0){1'b0}}, preset_d} > (TB+1)'(TMAX) ?
           (TB+1)'(TMAX) : (TB+1)'(preset_d);
      p = pw[TB-1:0];
      tin = trig;
      if (fl_d[F_TQ]) begin
        if (pe_d < p) pe_d = pe_d + 1'b1;
        if (pe_d >= p) fl_d[F_TQ] = 1'b0;
      end else if (tin && !fl_d[F_TI]) begin
        pe_d = '0;
        fl_d[F_TQ] = (p != '0);
      end else if (!tin) begin
        pe_d = '0;
      end
      fl_d[F_TI] = tin;
    end
    q = fl_d[F_TQ];
    if (q && !fl_d[F_PT] && !fresh) fl_d[F_V] = 1'b1;
    fl_d[F_PT] = q;
    clk = q && autom;
    fall = !clk && fl_d[F_PF];
    fl_d[F_PF] = clk;
    if ((fall && !fresh) || !volt) fl_d[F_V] = 1'b0;

    r = ondly(rf_t_q, fl_d[F_RI], P_REFILL); rf_t_d = r[TB-1:0]; q = r[TB];
    if (!fresh) begin
      fl_d[F_RI] = !fl_d[F_LB];
      if (fl_d[F_LB] && volt && autom) begin
        fl_d[F_RA] = 1'b1; fl_d[F_V] = 1'b1;
      end
      if ((q || !autom) && fl_d[F_RA]) begin
        fl_d[F_RA] = 1'b0; fl_d[F_V] = 1'b0;
      end
    end else begin
      fl_d[F_RI] = 1'b0; fl_d[F_RA] = 1'b0;
    end

    r = ondly(sc_t_q, fl_d[F_V] && full, P_SAFETY); sc_t_d = r[TB-1:0];
    if (r[TB]) fl_d[F_V] = 1'b0;

    cr = fl_d[F_C] && !fl_d[F_PC];
    fl_d[F_PC] = fl_d[F_C];

    if (fchk_q) begin
      if (fresh) begin
        r = ondly(fs_t_q, fl_d[F_V], P_FSTART); fs_t_d = r[TB-1:0]; q = r[TB];
        if (q && !flow) fl_d[F_FA] = 1'b1;
      end else begin
        r = ondly(fs_t_q, fl_d[F_P], P_FSTART); fs_t_d = r[TB-1:0]; q = r[TB];
        r = ondly(nf_t_q, !flow && !fl_d[F_V], P_NOFLOW); nf_t_d = r[TB-1:0]; d = r[TB];
        if (q && d) fl_d[F_FA] = 1'b1;
      end
    end else begin
      fl_d[F_FA] = 1'b0;
    end

    r = ondly(co_t_q, fl_d[F_LB] && !cr, P_CUTOFF); co_t_d = r[TB-1:0]; q = r[TB];
    if (q || !volt || fl_d[F_FA]) begin
      fl_d[F_P] = 1'b0; fl_d[F_C] = 1'b0;
    end else begin
      fl_d[F_P] = fl_d[F_C];
    end

    out_d = {3'b000, left, held_d, fl_d[F_FA], lalarm, fl_d[F_LB], fl_d[F_P], fl_d[F_V]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rtlvp_pkg::ST_IDLE; ovld_q <= 1'b0;
      ok_t_q <= '0; low_t_q <= '0; err_t_q <= '0; fs_t_q <= '0; nf_t_q <= '0;
      rf_t_q <= '0; co_t_q <= '0; sc_t_q <= '0; pe_q <= '0;
      preset_q <= '0; latest_q <= '0; held_q <= '0; pcnt_q <= '0; acnt_q <= '0;
      fl_q <= '0;
    end else begin
      st_q <= st_d;
      if (capt) begin
        ok_t_q <= ok_t_d; low_t_q <= low_t_d; err_t_q <= err_t_d; fs_t_q <= fs_t_d;
        nf_t_q <= nf_t_d; rf_t_q <= rf_t_d; co_t_q <= co_t_d; sc_t_q <= sc_t_d;
        pe_q <= pe_d; preset_q <= preset_d; latest_q <= latest_d; held_q <= held_d;
        pcnt_q <= pcnt_d; acnt_q <= acnt_d; fl_q <= fl_d;
        ovld_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_q <= s_axis_tdata[20:0];
    if (capt) out_q <= out_d;
    prod_q <= prod_d;
    quo_q <= quo_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;

  `RT_ASSERT_IMP(a_no_accept_busy, st_q != rtlvp_pkg::ST_IDLE, !s_axis_tready)
  `RT_ASSERT_NEXT(a_div_starts, dreq.start, drsp.busy)
  `RT_ASSERT_NEXT(a_apply_valid, st_q == rtlvp_pkg::ST_APPLY, m_axis_tvalid)
endmodule
